@@ hw/rtl/rcfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcfd_pkg: shared types and constants for the RC frame decoder
// Field widths, reset values, status codes and the result record.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    localparam int DEF_CHANNEL_COUNT = 6;
    localparam int DEF_FRAME_BYTES   = 32;
    localparam int OUT_CHANNELS      = 6;
    localparam int BYTE_W            = 8;
    localparam int CHAN_W            = 16;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h20;
    localparam logic [CHAN_W-1:0] CHECK_INIT   = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MISMATCH   = 2'd1,
        ST_BAD_HEADER = 2'd2
    } t_frame_status;

    typedef struct packed {
        logic [OUT_CHANNELS-1:0][CHAN_W-1:0] channels;
        t_frame_status                       status;
        logic [CHAN_W-1:0]                   rx_sum;
    } t_result;

endpackage

@@ hw/rtl/rcfd_in_if.sv @@
// ----------------------------------------------------------------------------
// rcfd_in_if: byte request channel
// Carries one received frame byte and its start-of-frame flag.
// ----------------------------------------------------------------------------
interface rcfd_in_if
    import rcfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

@@ hw/rtl/rcfd_out_if.sv @@
// ----------------------------------------------------------------------------
// rcfd_out_if: decoded frame request channel
// Carries six channel values, frame status and the received checksum.
// ----------------------------------------------------------------------------
interface rcfd_out_if
    import rcfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel_one;
    logic [CHAN_W-1:0] channel_two;
    logic [CHAN_W-1:0] channel_three;
    logic [CHAN_W-1:0] channel_four;
    logic [CHAN_W-1:0] channel_five;
    logic [CHAN_W-1:0] channel_six;
    logic [1:0]        frame_status;
    logic [CHAN_W-1:0] received_checksum;

    modport source (
        output valid, output channel_one, output channel_two, output channel_three,
        output channel_four, output channel_five, output channel_six,
        output frame_status, output received_checksum, input ready
    );
    modport sink (
        input valid, input channel_one, input channel_two, input channel_three,
        input channel_four, input channel_five, input channel_six,
        input frame_status, input received_checksum, output ready
    );
endinterface

@@ hw/rtl/rc_ibus_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// rc_ibus_frame_decoder: RC receiver frame decoder
// Byte-wise frame parser with header check, channel extraction and checksum.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle unless both result slots are full; a byte
// enters an input register, is folded into the frame state by combinational
// logic (a 16-bit subtract and compare), and any result is registered into
// a result slot. A second result slot behind the output register lets bytes
// keep flowing while a finished frame waits to be taken; once both result
// slots are full the core stalls, and input ready drops as soon as a byte is
// waiting in the input register. A start flag whose byte does not match the
// header register yields a bad-header result at once; the last frame byte
// yields the channels with ok or mismatch status. Bytes outside a frame are
// dropped. Write the header register only while the block is idle.
// ----------------------------------------------------------------------------
module rc_ibus_frame_decoder
    import rcfd_pkg::*;
#(
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
    parameter int FRAME_BYTES   = DEF_FRAME_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BYTE_W-1:0] i_cfg_wr_data,
    rcfd_in_if.sink           i_in,
    rcfd_out_if.source        o_out
);
    // header register
    logic [BYTE_W-1:0] r_header;

    // input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;

    // output register plus skid slot
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    w_fire;       // input stage consumed by the core this cycle
    logic    w_has_result;
    t_result w_result;
    logic    w_take;

    assign w_fire      = r_in_valid && !r_skid_valid;
    assign w_take      = r_out_valid && o_out.ready;
    assign i_in.ready  = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
        end else if (i_cfg_wr_en) begin
            r_header <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.data_byte;
            r_in_start <= i_in.frame_start;
        end
    end

    rcfd_core #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .FRAME_BYTES   (FRAME_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_fire),
        .i_byte       (r_in_byte),
        .i_start      (r_in_start),
        .i_header     (r_header),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    // A new result only arrives with the skid slot empty (see w_fire), so the
    // skid never has to drain and fill in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_fire && w_has_result) begin
                if (!r_out_valid || w_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has_result) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end else if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.channel_one       = r_out.channels[0];
    assign o_out.channel_two       = r_out.channels[1];
    assign o_out.channel_three     = r_out.channels[2];
    assign o_out.channel_four      = r_out.channels[3];
    assign o_out.channel_five      = r_out.channels[4];
    assign o_out.channel_six       = r_out.channels[5];
    assign o_out.frame_status      = r_out.status;
    assign o_out.received_checksum = r_out.rx_sum;

    // skid slot only ever holds the second of two queued results
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full with output register empty");

    // a result produced against a stalled full output must land in the skid
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_has_result && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("result lost while output stalled");

    // a bad-header result carries no checksum
    a_bad_header_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_BAD_HEADER) |-> (r_out.rx_sum == '0))
        else $error("bad-header result with nonzero checksum");
endmodule

@@ hw/rtl/rcfd_core.sv @@
// ----------------------------------------------------------------------------
// rcfd_core: frame state tracker
// Byte position, running checksum, channel store; builds the result record.
// ----------------------------------------------------------------------------
module rcfd_core
    import rcfd_pkg::*;
#(
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
    parameter int FRAME_BYTES   = DEF_FRAME_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_start,
    input  logic [BYTE_W-1:0] i_header,
    output logic              o_has_result,
    output t_result           o_result
);
    localparam int POS_W  = $clog2(FRAME_BYTES + 1);
    localparam int CH_END = 2 + 2 * CHANNEL_COUNT;

    localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_CSLO = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_CH0  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHE  = POS_W'(CH_END);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CHAN_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_hold, n_hold;
    logic              r_rej, n_rej;
    logic [CHAN_W-1:0] r_store [CHANNEL_COUNT];

    logic              w_ch_wr;
    logic [POS_W-1:0]  w_off;
    logic [CHAN_W-1:0] w_word;
    logic [OUT_CHANNELS-1:0][CHAN_W-1:0] w_chan;

    assign w_off  = r_pos - POS_CH0;
    assign w_word = {i_byte, r_hold};

    // channels above the configured count read as zero
    for (genvar k = 0; k < OUT_CHANNELS; k++) begin : g_out
        if (k < CHANNEL_COUNT) begin : g_live
            assign w_chan[k] = r_store[k];
        end else begin : g_zero
            assign w_chan[k] = '0;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_hold       = r_hold;
        n_rej        = r_rej;
        w_ch_wr      = 1'b0;
        o_has_result = 1'b0;
        o_result.channels = w_chan;
        o_result.status   = ST_OK;
        o_result.rx_sum   = '0;
        if (i_start) begin
            if (i_byte != i_header) begin
                n_rej             = 1'b1;
                n_pos             = POS_IDLE;
                o_has_result      = 1'b1;
                o_result.status   = ST_BAD_HEADER;
                o_result.channels = '0;
            end else begin
                n_rej = 1'b0;
                n_sum = CHECK_INIT - CHAN_W'(i_byte);
                n_pos = POS_W'(1);
            end
        end else if (r_pos >= POS_IDLE || r_rej) begin
            // no frame active: byte dropped
        end else if (r_pos < POS_CSLO) begin
            n_sum = r_sum - CHAN_W'(i_byte);
            if (r_pos >= POS_CH0 && r_pos < POS_CHE) begin
                if (!w_off[0]) begin
                    n_hold = i_byte;
                end else begin
                    w_ch_wr = 1'b1;
                end
            end
            n_pos = r_pos + POS_W'(1);
        end else if (r_pos == POS_CSLO) begin
            n_hold = i_byte;
            n_pos  = r_pos + POS_W'(1);
        end else begin
            o_has_result    = 1'b1;
            o_result.rx_sum = w_word;
            o_result.status = (w_word == r_sum) ? ST_OK : ST_MISMATCH;
            n_pos           = POS_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_IDLE;
            r_sum  <= CHECK_INIT;
            r_hold <= '0;
            r_rej  <= 1'b0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_hold <= n_hold;
            r_rej  <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CHANNEL_COUNT; k++) begin
            if (i_step && w_ch_wr && w_off[POS_W-1:1] == (POS_W-1)'(k)) begin
                r_store[k] <= w_word;
            end
        end
    end
endmodule
